/* rtl/core/owm_pkg.sv */
// shared types, phase codes and helpers for the one-wire bus master
`timescale 1ns / 1ps

package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TIME_W        = 10;
    localparam int PHASE_W       = 4;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int CFG_IDX_W     = 3;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RST_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RST_REC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W1_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W1_REL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W0_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RD_LOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RD_REL    = 3'd7;

    // bus phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RST_REC  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_W_LOW    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_W_REL    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_R_LOW    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_R_SAMPLE = 4'd7;
    localparam logic [PHASE_W-1:0] PH_R_REL    = 4'd8;

    typedef struct packed {
        logic [TIME_W-1:0] rst_low;
        logic [TIME_W-1:0] pres_wait;
        logic [TIME_W-1:0] rst_rec;
        logic [TIME_W-1:0] w1_low;
        logic [TIME_W-1:0] w1_rel;
        logic [TIME_W-1:0] w0_low;
        logic [TIME_W-1:0] rd_low;
        logic [TIME_W-1:0] rd_rel;
    } t_cfg;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] read_data;
        logic                     presence;
        logic                     done_res;
        logic                     busy_res;
        logic                     drive_low;
    } t_res;

    // a zero in a register whose range starts at one counts as one
    function automatic logic [TIME_W-1:0] min_one(input logic [TIME_W-1:0] v);
        min_one = (v == '0) ? TIME_W'(1) : v;
    endfunction

    function automatic logic phase_drive(input logic [PHASE_W-1:0] ph);
        phase_drive = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);
    endfunction

endpackage

/* rtl/core/owm_fsm.sv */
// bus phase sequencer: slot timer, bit counter and shift register
`timescale 1ns / 1ps

module owm_fsm
    import owm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [1:0]               i_kind,
    input  logic [BITS_PER_BYTE-1:0] i_data,
    input  logic                     i_line_in,
    input  t_cfg                     i_cfg,
    output t_res                     o_res
);

    logic [PHASE_W-1:0]       r_phase,    n_phase;
    logic [TIME_W-1:0]        r_tick_cnt, n_tick_cnt;
    logic [BIT_IDX_W-1:0]     r_bit_idx,  n_bit_idx;
    logic [BITS_PER_BYTE-1:0] r_shift,    n_shift;
    logic                     r_presence, n_presence;
    logic                     r_is_read,  n_is_read;
    logic [BITS_PER_BYTE-1:0] r_read_byte, n_read_byte;

    logic [PHASE_W-1:0] cur_phase;
    logic [TIME_W-1:0]  phase_len;
    logic [TIME_W-1:0]  tick_inc;
    logic               go_next_bit;
    logic               done_now;
    logic               drive;

    always_comb begin
        cur_phase = (r_phase > PH_R_REL) ? PH_IDLE : r_phase;
        unique case (cur_phase)
            PH_RST_LOW:  phase_len = min_one(i_cfg.rst_low);
            PH_RST_WAIT: phase_len = min_one(i_cfg.pres_wait);
            PH_RST_REC:  phase_len = i_cfg.rst_rec;
            PH_W_LOW:    phase_len = r_shift[0] ? min_one(i_cfg.w1_low)
                                                : min_one(i_cfg.w0_low);
            PH_W_REL:    phase_len = i_cfg.w1_rel;
            PH_R_LOW:    phase_len = min_one(i_cfg.rd_low);
            PH_R_REL:    phase_len = i_cfg.rd_rel;
            default:     phase_len = TIME_W'(1);
        endcase
        tick_inc = r_tick_cnt + TIME_W'(1);
    end

    always_comb begin
        n_phase     = cur_phase;
        n_tick_cnt  = r_tick_cnt;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_is_read   = r_is_read;
        n_read_byte = r_read_byte;
        go_next_bit = 1'b0;
        done_now    = 1'b0;
        drive       = 1'b0;

        if (i_kind == KIND_TICK) begin
            drive = phase_drive(cur_phase);
            if (cur_phase != PH_IDLE) begin
                n_tick_cnt = tick_inc;
                if (tick_inc >= phase_len) begin
                    n_tick_cnt = '0;
                    unique case (cur_phase)
                        PH_RST_LOW: begin
                            n_phase = PH_RST_WAIT;
                        end
                        PH_RST_WAIT: begin
                            n_presence = ~i_line_in;
                            if (i_cfg.rst_rec != '0) begin
                                n_phase = PH_RST_REC;
                            end else begin
                                n_phase  = PH_IDLE;
                                done_now = 1'b1;
                            end
                        end
                        PH_RST_REC: begin
                            n_phase  = PH_IDLE;
                            done_now = 1'b1;
                        end
                        PH_W_LOW: begin
                            if (r_shift[0] && (i_cfg.w1_rel != '0)) begin
                                n_phase = PH_W_REL;
                            end else begin
                                go_next_bit = 1'b1;
                            end
                        end
                        PH_R_LOW: begin
                            n_phase = PH_R_SAMPLE;
                        end
                        PH_R_SAMPLE: begin
                            n_shift = {i_line_in, r_shift[BITS_PER_BYTE-1:1]};
                            if (i_cfg.rd_rel != '0) begin
                                n_phase = PH_R_REL;
                            end else begin
                                go_next_bit = 1'b1;
                            end
                        end
                        PH_W_REL, PH_R_REL: begin
                            go_next_bit = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase

                    // advance to the next bit slot or close the byte
                    if (go_next_bit) begin
                        if (r_bit_idx == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
                            if (r_is_read) begin
                                n_read_byte = n_shift;
                            end
                            n_phase  = PH_IDLE;
                            done_now = 1'b1;
                        end else begin
                            n_bit_idx = r_bit_idx + BIT_IDX_W'(1);
                            if (r_is_read) begin
                                n_phase = PH_R_LOW;
                            end else begin
                                n_shift = {1'b0, r_shift[BITS_PER_BYTE-1:1]};
                                n_phase = PH_W_LOW;
                            end
                        end
                    end
                end
            end
        end else begin
            // commands while busy are dropped
            if (cur_phase == PH_IDLE) begin
                n_tick_cnt = '0;
                n_bit_idx  = '0;
                unique case (i_kind)
                    KIND_RESET: begin
                        n_presence = 1'b0;
                        n_phase    = PH_RST_LOW;
                    end
                    KIND_WRITE: begin
                        n_is_read = 1'b0;
                        n_shift   = i_data;
                        n_phase   = PH_W_LOW;
                    end
                    default: begin
                        n_is_read = 1'b1;
                        n_shift   = '0;
                        n_phase   = PH_R_LOW;
                    end
                endcase
            end
            drive = phase_drive(n_phase);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick_cnt  <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_is_read   <= 1'b0;
            r_read_byte <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_tick_cnt  <= n_tick_cnt;
            r_bit_idx   <= n_bit_idx;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_is_read   <= n_is_read;
            r_read_byte <= n_read_byte;
        end
    end

    always_comb begin
        o_res.drive_low = drive;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = done_now;
        o_res.presence  = n_presence;
        o_res.read_data = n_read_byte;
    end

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_R_REL)
        else $error("phase register out of range");

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res.done_res) |-> (r_phase != PH_IDLE) && !o_res.busy_res)
        else $error("done without a running operation");

    a_cmd_ignored_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_kind != KIND_TICK) && (r_phase != PH_IDLE))
            |=> (r_phase == $past(r_phase)) && (r_tick_cnt == $past(r_tick_cnt)))
        else $error("command altered a running operation");

    a_hold_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_phase) && $stable(r_tick_cnt) && $stable(r_shift))
        else $error("state moved without an input beat");

endmodule

/* rtl/core/one_wire_bus_master_core.sv */
// top level of the one-wire bus master: config registers, sequencer and output register
`timescale 1ns / 1ps

//  channel   direction  handshake                     payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata {line_in, data}, tuser kind
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata {read_data, presence,
//                                                        done_res, busy_res, drive_low}
//  cfg       in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
//  one input beat per cycle while not stalled; result registered at accept, offered next cycle
//  the sequencer update is a single pass: timer increment and compare, phase select
//  reset (i_rst_n low, synchronous) loads default timings and idles the bus
//  the input side stays ready while the output register is empty or being drained
//  a stalled output holds its beat and blocks only new input beats

module one_wire_bus_master_core
    import owm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data,
    // input beats
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,  // data[7:0], line_in[8], zero [15:9]
    input  logic [1:0]           i_s_axis_tuser,  // kind[1:0]
    // result beats
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata   // drive_low[0], busy_res[1], done_res[2],
                                                  // presence[3], read_data[11:4], zero [15:12]
);

    t_cfg r_cfg;
    t_res step_res;
    t_res r_res;
    logic r_out_valid;
    logic in_accept;

    // output register may be refilled in the same cycle it drains
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // timing registers, with reset defaults counted in ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rst_low   <= TIME_W'(480);
            r_cfg.pres_wait <= TIME_W'(80);
            r_cfg.rst_rec   <= TIME_W'(400);
            r_cfg.w1_low    <= TIME_W'(1);
            r_cfg.w1_rel    <= TIME_W'(50);
            r_cfg.w0_low    <= TIME_W'(50);
            r_cfg.rd_low    <= TIME_W'(2);
            r_cfg.rd_rel    <= TIME_W'(60);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RST_LOW:   r_cfg.rst_low   <= i_cfg_data;
                REG_PRES_WAIT: r_cfg.pres_wait <= i_cfg_data;
                REG_RST_REC:   r_cfg.rst_rec   <= i_cfg_data;
                REG_W1_LOW:    r_cfg.w1_low    <= i_cfg_data;
                REG_W1_REL:    r_cfg.w1_rel    <= i_cfg_data;
                REG_W0_LOW:    r_cfg.w0_low    <= i_cfg_data;
                REG_RD_LOW:    r_cfg.rd_low    <= i_cfg_data;
                default:       r_cfg.rd_rel    <= i_cfg_data;
            endcase
        end
    end

    owm_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_kind    (i_s_axis_tuser),
        .i_data    (i_s_axis_tdata[BITS_PER_BYTE-1:0]),
        .i_line_in (i_s_axis_tdata[BITS_PER_BYTE]),
        .i_cfg     (r_cfg),
        .o_res     (step_res)
    );

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= step_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_res};

endmodule

/* tb/sv/one_wire_bus_master_core_tb.sv */
// self-checking testbench for the one-wire bus master core
`timescale 1ns / 1ps

module one_wire_bus_master_core_tb;
    import owm_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TIME_W-1:0]    i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata;  // data[7:0], line_in[8], zero [15:9]
    logic [1:0]           i_s_axis_tuser;  // kind[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [15:0]          o_m_axis_tdata;  // drive_low[0], busy_res[1], done_res[2],
                                           // presence[3], read_data[11:4], zero [15:12]

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    one_wire_bus_master_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // bus sequencer mirror: timing registers and slot state
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]        timing      [8];  // what the block holds
    logic [TIME_W-1:0]        next_timing [8];  // what the next phase loads
    logic [PHASE_W-1:0]       bus_phase;
    logic [TIME_W-1:0]        slot_ticks;
    logic [BIT_IDX_W-1:0]     bit_no;
    logic [BITS_PER_BYTE-1:0] shifter;
    logic                     pres_seen;
    logic                     reading;
    logic [BITS_PER_BYTE-1:0] last_read;
    logic                     op_ended;

    t_res owed_results [$];   // expected result beats, oldest first
    int   errors      = 0;
    int   items_sent  = 0;    // ticks and operation commands; commands sent while busy are not counted
    bit   calm        = 1'b0; // no idling on either side once set

    // directed plan: one row is a run of identical beats
    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       line;
        int         reps;   // 0: ticks until the running operation ends
        bit         typed;  // expected beat typed in below instead of predicted
        t_res       want;
    } t_plan_row;

    t_plan_row plan [$];

    // low and wait times of zero behave as one tick
    function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    function automatic logic pulls_low(input logic [PHASE_W-1:0] ph);
        return (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);
    endfunction

    // number of ticks the current phase lasts
    function automatic logic [TIME_W-1:0] slot_limit();
        case (bus_phase)
            PH_RST_LOW:  return at_least_one(timing[REG_RST_LOW]);
            PH_RST_WAIT: return at_least_one(timing[REG_PRES_WAIT]);
            PH_RST_REC:  return timing[REG_RST_REC];
            PH_W_LOW:    return shifter[0] ? at_least_one(timing[REG_W1_LOW])
                                           : at_least_one(timing[REG_W0_LOW]);
            PH_W_REL:    return timing[REG_W1_REL];
            PH_R_LOW:    return at_least_one(timing[REG_RD_LOW]);
            PH_R_REL:    return timing[REG_RD_REL];
            default:     return TIME_W'(1);
        endcase
    endfunction

    task automatic end_op();
        bus_phase = PH_IDLE;
        op_ended  = 1'b1;
    endtask

    // step to the next bit of the byte, or close the operation after bit 7
    task automatic advance_bit();
        if (bit_no == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
            if (reading)
                last_read = shifter;
            end_op();
        end else begin
            bit_no = bit_no + 1'b1;
            if (reading) begin
                bus_phase = PH_R_LOW;
            end else begin
                shifter   = shifter >> 1;
                bus_phase = PH_W_LOW;
            end
        end
    endtask

    // advance the mirror by one accepted beat and form the result it owes
    task automatic bus_step(input logic [1:0] kind, input logic [7:0] data,
                            input logic line, output t_res r);
        logic pull;
        op_ended = 1'b0;
        if (bus_phase > PH_R_REL)
            bus_phase = PH_IDLE;
        if (kind == KIND_TICK) begin
            // a tick reports the drive it ran under, then moves the timer
            pull = pulls_low(bus_phase);
            if (bus_phase != PH_IDLE) begin
                slot_ticks = slot_ticks + 1'b1;
                if (slot_ticks >= slot_limit()) begin
                    slot_ticks = '0;
                    case (bus_phase)
                        PH_RST_LOW:  bus_phase = PH_RST_WAIT;
                        PH_RST_WAIT: begin
                            // a slave answers by holding the line low
                            pres_seen = ~line;
                            if (timing[REG_RST_REC] != '0)
                                bus_phase = PH_RST_REC;
                            else
                                end_op();
                        end
                        PH_RST_REC:  end_op();
                        PH_W_LOW: begin
                            if (shifter[0] && timing[REG_W1_REL] != '0)
                                bus_phase = PH_W_REL;
                            else
                                advance_bit();
                        end
                        PH_R_LOW:    bus_phase = PH_R_SAMPLE;
                        PH_R_SAMPLE: begin
                            shifter = {line, shifter[7:1]};
                            if (timing[REG_RD_REL] != '0)
                                bus_phase = PH_R_REL;
                            else
                                advance_bit();
                        end
                        PH_W_REL, PH_R_REL: advance_bit();
                        default:     bus_phase = PH_IDLE;
                    endcase
                end
            end
        end else begin
            // commands start only on an idle bus, otherwise they fall through
            if (bus_phase == PH_IDLE) begin
                slot_ticks = '0;
                bit_no     = '0;
                case (kind)
                    KIND_RESET: begin
                        pres_seen = 1'b0;
                        bus_phase = PH_RST_LOW;
                    end
                    KIND_WRITE: begin
                        reading   = 1'b0;
                        shifter   = data;
                        bus_phase = PH_W_LOW;
                    end
                    default: begin
                        reading   = 1'b1;
                        shifter   = '0;
                        bus_phase = PH_R_LOW;
                    end
                endcase
            end
            pull = pulls_low(bus_phase);
        end
        r.drive_low = pull;
        r.busy_res  = (bus_phase != PH_IDLE);
        r.done_res  = op_ended;
        r.presence  = pres_seen;
        r.read_data = last_read;
    endtask

    // ------------------------------------------------------------------
    // input side: one beat per call, optional gap in front of it
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                             input logic line, input bit typed, input t_res want);
        t_res guess;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = kind;
        i_s_axis_tdata  = {7'd0, line, data};
        do @(posedge i_clk); while (!o_s_axis_tready);
        bus_step(kind, data, line, guess);
        owed_results.push_back(typed ? want : guess);
    endtask

    // stop sending and wait for every owed beat, plus the output register
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // load next_timing into the block while it sits idle
    task automatic apply_timing();
        drain_results();
        for (int i = int'(REG_RST_LOW); i <= int'(REG_RD_REL); i++) begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = CFG_IDX_W'(i);
            i_cfg_data = next_timing[i];
            timing[i]  = next_timing[i];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
    endtask

    // short random timings, zeros included so low times clamp and releases skip
    task automatic pick_short_timing();
        next_timing[REG_RST_LOW]   = TIME_W'($urandom_range(0, 5));
        next_timing[REG_PRES_WAIT] = TIME_W'($urandom_range(0, 5));
        next_timing[REG_RST_REC]   = TIME_W'($urandom_range(0, 5));
        next_timing[REG_W1_LOW]    = TIME_W'($urandom_range(0, 4));
        next_timing[REG_W1_REL]    = TIME_W'($urandom_range(0, 4));
        next_timing[REG_W0_LOW]    = TIME_W'($urandom_range(0, 5));
        next_timing[REG_RD_LOW]    = TIME_W'($urandom_range(0, 3));
        next_timing[REG_RD_REL]    = TIME_W'($urandom_range(0, 4));
    endtask

    // one full operation with random line levels; now and then a stray command
    // lands while busy and a few ticks arrive while the bus is idle
    task automatic run_op(input logic [1:0] op, input logic [7:0] payload);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
                items_sent++;
            end
        end
        send_item(op, payload, 1'($urandom), 1'b0, '0);
        items_sent++;
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom), 1'b0, '0);
            end else begin
                send_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
                items_sent++;
            end
        end
    endtask

    task automatic random_ops(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget)
            run_op(2'($urandom_range(1, 3)), 8'($urandom));
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [7:0] data, input logic line,
                           input int reps, input bit typed, input t_res want);
        t_plan_row row;
        row.kind  = kind;
        row.data  = data;
        row.line  = line;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    function automatic t_res res_of(input logic drive, input logic busy, input logic done,
                                    input logic pres, input logic [7:0] rd);
        t_res r;
        r.drive_low = drive;
        r.busy_res  = busy;
        r.done_res  = done;
        r.presence  = pres;
        r.read_data = rd;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // output side: random stall bursts on tready
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // every result beat is matched against the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_res'(o_m_axis_tdata[11:0]);
            if (owed_results.size() == 0) begin
                $error("result beat %h arrived with nothing owed", o_m_axis_tdata);
                errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("drive_low", want.drive_low, got.drive_low);
                check_field("busy_res",  want.busy_res,  got.busy_res);
                check_field("done_res",  want.done_res,  got.done_res);
                check_field("presence",  want.presence,  got.presence);
                check_field("read_data", want.read_data, got.read_data);
            end
        end
    end

    // hard stop: the slowest legal run, with every gap and stall at its longest,
    // stays well below this
    initial begin : watchdog
        #25_000_000;
        $display("one_wire_bus_master_core_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        // timings the block loads on reset
        timing[REG_RST_LOW]   = 10'd480;
        timing[REG_PRES_WAIT] = 10'd80;
        timing[REG_RST_REC]   = 10'd400;
        timing[REG_W1_LOW]    = 10'd1;
        timing[REG_W1_REL]    = 10'd50;
        timing[REG_W0_LOW]    = 10'd50;
        timing[REG_RD_LOW]    = 10'd2;
        timing[REG_RD_REL]    = 10'd60;
        bus_phase  = PH_IDLE;
        slot_ticks = '0;
        bit_no     = '0;
        shifter    = '0;
        pres_seen  = 1'b0;
        reading    = 1'b0;
        last_read  = '0;
        op_ended   = 1'b0;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_RST_LOW;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_TICK;

        // directed plan at reset timings
        // idle ticks right after reset, data ignored on ticks
        add_row(KIND_TICK,  8'h00, 1'b1, 2, 1'b1, res_of(0, 0, 0, 0, 8'h00));
        add_row(KIND_TICK,  8'hFF, 1'b0, 1, 1'b1, res_of(0, 0, 0, 0, 8'h00));
        // bus reset: pulse low, then a write command that must be dropped
        add_row(KIND_RESET, 8'h00, 1'b1, 1, 1'b1, res_of(1, 1, 0, 0, 8'h00));
        add_row(KIND_WRITE, 8'hA5, 1'b1, 1, 1'b1, res_of(1, 1, 0, 0, 8'h00));
        add_row(KIND_TICK,  8'h00, 1'b1, 480, 1'b0, '0);
        // presence window: line pulled low by a slave on the sampling tick
        add_row(KIND_TICK,  8'h00, 1'b1, 79, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1, 1'b0, '0);
        // read command during recovery is dropped too
        add_row(KIND_READ,  8'h00, 1'b1, 1, 1'b1, res_of(0, 1, 0, 1, 8'h00));
        add_row(KIND_TICK,  8'h00, 1'b1, 0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b1, 1, 1'b1, res_of(0, 0, 0, 1, 8'h00));
        // all-ones and all-zeros bytes: short and long low pulses
        add_row(KIND_WRITE, 8'hFF, 1'b1, 1, 1'b1, res_of(1, 1, 0, 1, 8'h00));
        add_row(KIND_TICK,  8'h00, 1'b0, 0, 1'b0, '0);
        add_row(KIND_WRITE, 8'h00, 1'b1, 1, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b1, 0, 1'b0, '0);
        // reads of a released line and of a line held low
        add_row(KIND_READ,  8'h00, 1'b1, 1, 1'b1, res_of(1, 1, 0, 1, 8'h00));
        add_row(KIND_TICK,  8'h00, 1'b1, 0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1, 1'b1, res_of(0, 0, 0, 1, 8'hFF));
        add_row(KIND_READ,  8'hFF, 1'b0, 1, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 0, 1'b0, '0);
        // reset with no slave answering clears presence
        add_row(KIND_RESET, 8'h00, 1'b0, 1, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b1, 0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b1, 1, 1'b1, res_of(0, 0, 0, 0, 8'h00));
        add_row(KIND_WRITE, 8'h5A, 1'b0, 1, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b1, 0, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k]) begin
            if (plan[k].reps == 0) begin
                while (bus_phase != PH_IDLE)
                    send_item(KIND_TICK, plan[k].data, plan[k].line, 1'b0, '0);
            end else begin
                repeat (plan[k].reps)
                    send_item(plan[k].kind, plan[k].data, plan[k].line,
                              plan[k].typed, plan[k].want);
            end
        end

        // all registers zero: low times clamp to one tick, releases and recovery skip
        foreach (next_timing[i]) next_timing[i] = '0;
        apply_timing();
        random_ops(120);

        // all registers at their top value: one operation of each kind
        foreach (next_timing[i]) next_timing[i] = '1;
        apply_timing();
        run_op(KIND_RESET, 8'($urandom));
        run_op(KIND_WRITE, 8'($urandom));
        run_op(KIND_READ,  8'($urandom));

        // short random timings with gaps and stalls
        pick_short_timing();
        apply_timing();
        random_ops(150);

        // last stretch at full rate on both sides
        pick_short_timing();
        apply_timing();
        calm = 1'b1;
        random_ops(130);

        drain_results();
        repeat (2) @(posedge i_clk);
        if (errors == 0)
            $display("one_wire_bus_master_core_tb: PASS");
        else
            $display("one_wire_bus_master_core_tb: FAIL");
        $finish;
    end

endmodule
